// ===== hw/rtl/mla_pkg.sv =====
// Shared constants, types and exponential tables for the Mish activation lanes.
// Used by the channel interfaces, the pipeline control, the lane datapath and the top level.
// No dependencies.
package mla_pkg;

    localparam int LANES_DEFAULT = 4;

    // Pixel values are signed Q8.8.
    localparam int PIX_W = 16;

    // Configuration register widths.
    localparam int CNT_W = 21;
    localparam int IDX_W = 20;
    localparam int CFG_W = CNT_W;

    // Magnitudes at or above 2^MAG_BITS give zero for negative inputs, and positive
    // inputs at or above 2^(MAG_BITS-1) come out unchanged, so only MAG_BITS bits
    // of magnitude reach the datapath.
    localparam int MAG_BITS = 12;
    localparam int TAB_BITS = MAG_BITS / 2;
    localparam int TAB_SIZE = 1 << TAB_BITS;

    // Fraction bits of t = e^(-|x|), of the quotient, and the divider widths.
    localparam int FRAC_BITS = 32;
    localparam int EXP_W = FRAC_BITS + 1;
    localparam int PROD_W = 2 * EXP_W;
    localparam int NUM_W = FRAC_BITS + 2;
    localparam int DEN_W = FRAC_BITS + 3;
    localparam int DIV_BITS = 32;
    localparam int SUM_W = MAG_BITS + DIV_BITS + 1;

    // Lane pipeline stages.
    localparam int ST_LOOKUP = 0;
    localparam int ST_EXP = 1;
    localparam int ST_SQUARE = 2;
    localparam int ST_FRAC = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_ROUND = ST_DIV0 + DIV_BITS;
    localparam int LANE_STAGES = ST_ROUND + 1;
    // The merge register behind the lanes is the last stage.
    localparam int PIPE_DEPTH = LANE_STAGES + 1;

    typedef enum logic [0:0] {
        REG_ENABLE      = 1'b0,
        REG_PIXEL_COUNT = 1'b1
    } mla_reg_t;

    typedef logic [TAB_SIZE-1:0][EXP_W-1:0] mla_exp_tab_t;

    // Per-value information that travels with a lane value down the pipeline.
    typedef struct packed {
        logic [PIX_W-1:0]    x;
        logic                neg;
        logic                pass;
        logic                zero;
        logic [MAG_BITS-1:0] mag;
    } mla_side_t;

    typedef struct packed {
        mla_side_t           side;
        logic [MAG_BITS-1:0] m;
    } mla_lane_res_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] lane_load;
        logic                   out_load;
        logic                   out_valid;
        logic                   out_last;
    } mla_pipe_ctl_t;

    // e^(-i*step/256) in Q1.FRAC_BITS for i = 0 .. TAB_SIZE-1, rounded to nearest.
    // Only ever evaluated at elaboration.
    function automatic mla_exp_tab_t exp_table(input int step);
        mla_exp_tab_t tab;
        real          v;
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            v = $exp(-real'(i * step) / 256.0) * (2.0 ** FRAC_BITS);
            tab[i] = EXP_W'(longint'(v));
        end
        return tab;
    endfunction

    localparam mla_exp_tab_t EXP_LO = exp_table(1);
    localparam mla_exp_tab_t EXP_HI = exp_table(TAB_SIZE);

endpackage

// ===== hw/rtl/mla_if.sv =====
// Valid/ready channel interfaces for pixel items and result items.
// Depends on mla_pkg for the value width and the default lane count.
interface mla_pixel_if #(
    parameter int LANES = mla_pkg::LANES_DEFAULT
) ();
    logic                             valid;
    logic                             ready;
    logic [LANES-1:0][mla_pkg::PIX_W-1:0] lane;

    modport source (output valid, output lane, input ready);
    modport sink (input valid, input lane, output ready);
endinterface

interface mla_result_if #(
    parameter int LANES = mla_pkg::LANES_DEFAULT
) ();
    logic                             valid;
    logic                             ready;
    logic [LANES-1:0][mla_pkg::PIX_W-1:0] res;
    logic                             frame_last;

    modport source (output valid, output res, output frame_last, input ready);
    modport sink (input valid, input res, input frame_last, output ready);
endinterface

// ===== hw/rtl/mla_ctrl.sv =====
// Pipeline control shared by all lanes: per-stage valid bits with bubble collapsing,
// stage load enables and the frame position counter. Depends on mla_pkg.
module mla_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   out_ready,
    input  logic [mla_pkg::CNT_W-1:0] pixel_count,
    output mla_pkg::mla_pipe_ctl_t ctl
);
    import mla_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] last_reg;
    logic [PIPE_DEPTH-1:0] stage_ready;
    logic [PIPE_DEPTH-1:0] prev_valid;
    logic [PIPE_DEPTH-1:0] prev_last;
    logic [PIPE_DEPTH-1:0] load;
    logic [IDX_W-1:0]      pixel_index_reg;
    logic [IDX_W-1:0]      pixel_index_next;
    logic [CNT_W-1:0]      index_inc;
    logic                  frame_end;

    // A stage can take a new item when the output moves or some stage at or after it is empty.
    for (genvar i = 0; i < PIPE_DEPTH; i++)
    begin : g_ready
        assign stage_ready[i] = out_ready || !(&valid_reg[PIPE_DEPTH-1:i]);
    end

    assign prev_valid = {valid_reg[PIPE_DEPTH-2:0], in_valid};
    assign prev_last  = {last_reg[PIPE_DEPTH-2:0], frame_end};
    assign load       = stage_ready & prev_valid;
    assign in_ready   = stage_ready[0];

    assign index_inc        = CNT_W'(pixel_index_reg) + CNT_W'(1);
    assign frame_end        = index_inc >= pixel_count;
    assign pixel_index_next = frame_end ? '0 : index_inc[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            last_reg        <= '0;
            pixel_index_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_reg & ~stage_ready) | (prev_valid & stage_ready);
            last_reg  <= (last_reg & ~load) | (prev_last & load);
            if (load[0])
            begin
                pixel_index_reg <= pixel_index_next;
            end
        end
    end

    assign ctl.lane_load = load[LANE_STAGES-1:0];
    assign ctl.out_load  = load[PIPE_DEPTH-1];
    assign ctl.out_valid = valid_reg[PIPE_DEPTH-1];
    assign ctl.out_last  = last_reg[PIPE_DEPTH-1];

    // The frame position returns to zero after a pixel that closes a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && frame_end) |=> (pixel_index_reg == '0))
        else $error("frame position did not wrap after the last pixel");

    // Whenever the output side takes, the input side can take as well.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while the output was draining");

    // Items in flight change only by accepted and delivered items.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(in_valid && in_ready))
            - int'($past(valid_reg[PIPE_DEPTH-1] && out_ready))))
        else $error("pipeline item count is inconsistent");

endmodule

// ===== hw/rtl/mla_lane.sv =====
// One Mish lane: exponential from two tables, squaring, a bit-per-stage restoring
// divider for tanh(softplus) and a rounding multiply. Depends on mla_pkg.
module mla_lane (
    input  logic                       clk,
    input  logic [mla_pkg::LANE_STAGES-1:0] load,
    input  logic [mla_pkg::PIX_W-1:0]  x,
    output mla_pkg::mla_lane_res_t     res
);
    import mla_pkg::*;

    mla_side_t           side_in;
    mla_side_t           side_reg [LANE_STAGES];
    logic [PIX_W:0]      x_ext;
    logic [PIX_W:0]      mag_full;
    logic [EXP_W-1:0]    a_reg;
    logic [EXP_W-1:0]    b_reg;
    logic [PROD_W-1:0]   t_prod;
    logic [EXP_W-1:0]    t_reg;
    logic [EXP_W-1:0]    t_sq_reg;
    logic [PROD_W-1:0]   t2_prod;
    logic [EXP_W-1:0]    t2_reg;
    logic [NUM_W-1:0]    num_comb;
    logic [DEN_W-1:0]    den_comb;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg [DIV_BITS];
    logic [DIV_BITS-1:0] quo_reg [DIV_BITS];
    logic [DEN_W-1:0]    dvs_reg [DIV_BITS-1];
    logic [SUM_W-1:0]    round_sum;
    logic [MAG_BITS-1:0] m_reg;

    // Stage 0: sign, magnitude, range shortcuts and table lookup.
    assign x_ext    = {x[PIX_W-1], x};
    assign mag_full = x[PIX_W-1] ? (~x_ext + (PIX_W+1)'(1)) : x_ext;

    always_comb
    begin
        side_in.x    = x;
        side_in.neg  = x[PIX_W-1];
        side_in.pass = !x[PIX_W-1] && (mag_full[PIX_W:MAG_BITS-1] != '0);
        side_in.zero = x[PIX_W-1] && (mag_full[PIX_W:MAG_BITS] != '0);
        side_in.mag  = mag_full[MAG_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_LOOKUP])
        begin
            side_reg[ST_LOOKUP] <= side_in;
            a_reg <= EXP_HI[mag_full[MAG_BITS-1:TAB_BITS]];
            b_reg <= EXP_LO[mag_full[TAB_BITS-1:0]];
        end
    end

    for (genvar s = 1; s < LANE_STAGES; s++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (load[s])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // Stage 1: t = e^(-|x|) as the product of the two table entries.
    assign t_prod = {{EXP_W{1'b0}}, a_reg} * {{EXP_W{1'b0}}, b_reg};

    always_ff @(posedge clk)
    begin
        if (load[ST_EXP])
        begin
            t_reg <= t_prod[FRAC_BITS+EXP_W-1:FRAC_BITS];
        end
    end

    // Stage 2: t squared.
    assign t2_prod = {{EXP_W{1'b0}}, t_reg} * {{EXP_W{1'b0}}, t_reg};

    always_ff @(posedge clk)
    begin
        if (load[ST_SQUARE])
        begin
            t_sq_reg <= t_reg;
            t2_reg   <= t2_prod[FRAC_BITS+EXP_W-1:FRAC_BITS];
        end
    end

    // Stage 3: numerator and denominator of tanh(softplus(x)), written so that
    // t stays below one for either sign.
    always_comb
    begin
        if (side_reg[ST_SQUARE].neg)
        begin
            num_comb = {1'b0, t2_reg} + {t_sq_reg, 1'b0};
            den_comb = {1'b0, num_comb} + (DEN_W'(2) << FRAC_BITS);
        end
        else
        begin
            num_comb = (NUM_W'(1) << FRAC_BITS) + {t_sq_reg, 1'b0};
            den_comb = {1'b0, num_comb} + {1'b0, t2_reg, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[ST_FRAC])
        begin
            num_reg <= num_comb;
            den_reg <= den_comb;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        logic [DEN_W-1:0]    rem_in;
        logic [DEN_W-1:0]    dvs_in;
        logic [DIV_BITS-1:0] quo_in;
        logic [DEN_W:0]      shifted;
        logic [DEN_W:0]      diff;
        logic                take;

        if (k == 0)
        begin : g_first
            assign rem_in = {1'b0, num_reg};
            assign dvs_in = den_reg;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign diff    = shifted - {1'b0, dvs_in};
        assign take    = shifted >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            if (load[ST_DIV0+k])
            begin
                rem_reg[k] <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                quo_reg[k] <= {quo_in[DIV_BITS-2:0], take};
            end
        end

        if (k < DIV_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (load[ST_DIV0+k])
                begin
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    end

    // Final stage: |x| times the quotient, rounded to nearest.
    assign round_sum = {{(SUM_W-MAG_BITS){1'b0}}, side_reg[ST_ROUND-1].mag}
                     * {{(SUM_W-DIV_BITS){1'b0}}, quo_reg[DIV_BITS-1]}
                     + (SUM_W'(1) << (DIV_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (load[ST_ROUND])
        begin
            m_reg <= round_sum[DIV_BITS+MAG_BITS-1:DIV_BITS];
        end
    end

    assign res.side = side_reg[ST_ROUND];
    assign res.m    = m_reg;

endmodule

// ===== hw/rtl/mish_activation_lanes.sv =====
// Top level of the Mish activation: configuration registers, shared pipeline control,
// LANES Mish lanes and the merge register. Depends on mla_pkg, mla_if, mla_ctrl, mla_lane.
//
//   channel  direction  handshake         payload
//   pixel    in         valid / ready     lane[LANES] signed Q8.8
//   result   out        valid / ready     res[LANES] signed Q8.8, frame_last
//   cfg      in         cfg_we            cfg_addr, cfg_wdata
//
// One pixel enters per cycle while pixel.ready is high; its result is offered after passing
// through 38 register stages, a depth set by the 32 one-bit stages of the restoring divider
// in each lane.
// Reset clears the stage valid bits, the frame position and the registers
// (enable off, one pixel per frame).
// A stalled output only holds the full stages; empty stages keep filling, so pixel.ready
// stays high while any stage is free.
module mish_activation_lanes #(
    parameter int LANES = mla_pkg::LANES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_addr,
    input  logic [mla_pkg::CFG_W-1:0] cfg_wdata,
    mla_pixel_if.sink                 pixel,
    mla_result_if.source              result
);
    import mla_pkg::*;

    logic                         enable_reg;
    logic [CNT_W-1:0]             pixel_count_reg;
    logic                         in_ready;
    mla_pipe_ctl_t                ctl;
    mla_lane_res_t                lane_res [LANES];
    logic [LANES-1:0][PIX_W-1:0]  res_next;
    logic [LANES-1:0][PIX_W-1:0]  res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            pixel_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENABLE:      enable_reg <= cfg_wdata[0];
                REG_PIXEL_COUNT: pixel_count_reg <= cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    mla_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pixel.valid),
        .in_ready    (in_ready),
        .out_ready   (result.ready),
        .pixel_count (pixel_count_reg),
        .ctl         (ctl)
    );

    assign pixel.ready = in_ready;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        mla_lane u_lane (
            .clk  (clk),
            .load (ctl.lane_load),
            .x    (pixel.lane[g]),
            .res  (lane_res[g])
        );
    end

    // Merge: choose between passthrough, the range shortcuts and the signed Mish value.
    always_comb
    begin
        for (int g = 0; g < LANES; g++)
        begin
            if (!enable_reg || lane_res[g].side.pass)
            begin
                res_next[g] = lane_res[g].side.x;
            end
            else if (lane_res[g].side.zero)
            begin
                res_next[g] = '0;
            end
            else if (lane_res[g].side.neg)
            begin
                res_next[g] = ~{{(PIX_W-MAG_BITS){1'b0}}, lane_res[g].m} + PIX_W'(1);
            end
            else
            begin
                res_next[g] = {{(PIX_W-MAG_BITS){1'b0}}, lane_res[g].m};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid      = ctl.out_valid;
    assign result.res        = res_reg;
    assign result.frame_last = ctl.out_last;

endmodule

// ===== verif/tb_mish_activation_lanes.sv =====
// Self-checking testbench for mish_activation_lanes: directed pixel table, random traffic
// and a closing pass at the widest frame count, each item checked against its table row or a
// predictor. Depends on mla_pkg, mla_pixel_if, mla_result_if and the RTL top level.
module tb_mish_activation_lanes;
    timeunit 1ns;
    timeprecision 1ps;

    import mla_pkg::*;

    localparam int LANES       = LANES_DEFAULT;
    localparam int CYCLE_LIMIT = 100_000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 10;
    // Pixels sent at the widest frame count, where no frame_last is expected.
    localparam int WIDE_PASS   = 80;

    localparam logic [63:0] ONE62 = 64'd1 << 62;
    localparam logic [63:0] ONE60 = 64'd1 << 60;

    typedef logic [LANES-1:0][PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t res;
        logic   last;
    } frame_out_t;

    // Lanes are written as one hex word, lane 3 leftmost down to lane 0.
    typedef struct packed {
        logic             en;
        logic [CFG_W-1:0] cnt;
        pixel_t           lanes;
        logic             typed;
        pixel_t           want_res;
        logic             want_last;
    } stim_row_t;

    typedef struct packed {
        logic             en;
        logic [CFG_W-1:0] cnt;
        logic [15:0]      items;
        logic             hold;
        logic             gaps;
    } phase_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    mla_pixel_if #(.LANES(LANES))  pix ();
    mla_result_if #(.LANES(LANES)) res_ch ();

    mish_activation_lanes #(.LANES(LANES)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pixel     (pix),
        .result    (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the registers and of the frame position.
    logic             cfg_enable;
    logic [CFG_W-1:0] cfg_count;
    logic [IDX_W-1:0] frame_pos;

    frame_out_t pending_results [$];

    int  cycle_count    = 0;
    int  mismatches     = 0;
    int  pixels_sent    = 0;
    int  mish_pixels    = 0;
    int  results_seen   = 0;
    int  last_marks     = 0;
    int  settings_used  = 0;
    int  stall_requests = 0;
    int  stall_served   = 0;
    bit  gaps_on        = 1'b1;

    stim_row_t directed_rows [19] = '{
        // Reset settings: pass through, every pixel closes a frame.
        '{1'b0, 21'd1, 64'h8000_7FFF_FFFF_0000, 1'b1, 64'h8000_7FFF_FFFF_0000, 1'b1},
        '{1'b0, 21'd1, 64'h5555_7FFE_8001_0001, 1'b1, 64'h5555_7FFE_8001_0001, 1'b1},
        '{1'b0, 21'd1, 64'h0100_FF00_00FF_AAAA, 1'b1, 64'h0100_FF00_00FF_AAAA, 1'b1},
        // Mish at the extremes: large positives come out unchanged, large negatives give 0.
        '{1'b1, 21'd1, 64'h4000_8000_7FFF_0000, 1'b1, 64'h4000_0000_7FFF_0000, 1'b1},
        '{1'b1, 21'd1, 64'h7F00_2000_F000_E000, 1'b1, 64'h7F00_2000_0000_0000, 1'b1},
        '{1'b1, 21'd1, 64'hFF00_0100_FFFF_0001, 1'b0, 64'h0, 1'b0},
        '{1'b1, 21'd1, 64'hF600_0A00_FF80_0080, 1'b0, 64'h0, 1'b0},
        '{1'b1, 21'd1, 64'h0700_F900_FED0_FECD, 1'b0, 64'h0, 1'b0},
        '{1'b1, 21'd1, 64'h0500_FB00_F600_FD80, 1'b0, 64'h0, 1'b0},
        '{1'b1, 21'd1, 64'h3FFF_C000_1000_F800, 1'b0, 64'h0, 1'b0},
        // Frames of three pixels.
        '{1'b0, 21'd3, 64'h1234_5678_9ABC_DEF0, 1'b1, 64'h1234_5678_9ABC_DEF0, 1'b0},
        '{1'b0, 21'd3, 64'h0F0F_F0F0_3C3C_C3C3, 1'b1, 64'h0F0F_F0F0_3C3C_C3C3, 1'b0},
        '{1'b0, 21'd3, 64'hFFFF_0000_FFFF_0000, 1'b1, 64'hFFFF_0000_FFFF_0000, 1'b1},
        '{1'b0, 21'd3, 64'h0000_FFFF_0000_FFFF, 1'b1, 64'h0000_FFFF_0000_FFFF, 1'b0},
        '{1'b0, 21'd3, 64'h7FFF_7FFF_8000_8000, 1'b1, 64'h7FFF_7FFF_8000_8000, 1'b0},
        // Count lowered below the position: the next pixel closes the frame.
        '{1'b0, 21'd2, 64'h0001_0002_0004_0008, 1'b1, 64'h0001_0002_0004_0008, 1'b1},
        // A zero count closes every frame.
        '{1'b0, 21'd0, 64'h00AA_5500_AA00_0055, 1'b1, 64'h00AA_5500_AA00_0055, 1'b1},
        '{1'b0, 21'd0, 64'hDEAD_BEEF_CAFE_F00D, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 1'b1},
        '{1'b1, 21'd5, 64'h0180_FE80_0300_FD00, 1'b0, 64'h0, 1'b0}
    };

    phase_t random_phases [9] = '{
        '{1'b1, 21'd1,       16'd150, 1'b0, 1'b1},
        '{1'b1, 21'd7,       16'd150, 1'b0, 1'b1},
        '{1'b0, 21'd5,       16'd100, 1'b0, 1'b1},
        '{1'b1, 21'd1048576, 16'd150, 1'b0, 1'b1},
        '{1'b1, 21'd17,      16'd150, 1'b0, 1'b1},
        '{1'b0, 21'd0,       16'd80,  1'b0, 1'b1},
        '{1'b1, 21'd2,       16'd150, 1'b1, 1'b1},
        '{1'b1, 21'd13,      16'd150, 1'b0, 1'b1},
        '{1'b1, 21'd9,       16'd120, 1'b0, 1'b0}
    };

    // (a * b) >> sh, kept to 64 bits.
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p >> sh;
        return p[63:0];
    endfunction

    // e^(-mag/256) in Q0.62: Taylor series at mag/2^18, then squared ten times.
    function automatic logic [63:0] exp_decay(input logic [15:0] mag);
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] sum;
        r    = 64'(mag) << 44;
        term = ONE62;
        sum  = ONE62;
        for (int n = 1; n <= 24; n++)
        begin
            term = mul_shift(term, r, 62) / 64'(n);
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int n = 0; n < 10; n++)
            sum = mul_shift(sum, sum, 62);
        return sum;
    endfunction

    // Restoring division giving num/den in Q0.60.
    function automatic logic [63:0] ratio_q60(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = num;
        for (int i = 0; i < 60; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [PIX_W-1:0] mish_code(input logic [PIX_W-1:0] x);
        logic         neg;
        logic [15:0]  mag;
        logic [63:0]  t;
        logic [63:0]  t2;
        logic [63:0]  num;
        logic [63:0]  den;
        logic [63:0]  q;
        logic [127:0] p;
        logic [63:0]  m;
        neg = x[PIX_W-1];
        mag = neg ? (~x + 16'd1) : x;
        t   = exp_decay(mag) >> 2;
        t2  = mul_shift(t, t, 60);
        if (neg)
        begin
            num = t2 + (t << 1);
            den = num + (ONE60 << 1);
        end
        else
        begin
            num = ONE60 + (t << 1);
            den = num + (t2 << 1);
        end
        q = ratio_q60(num, den);
        // Round half away from zero on the magnitude, then apply the sign.
        p = 128'(mag) * 128'(q) + (128'd1 << 59);
        m = 64'(p >> 60);
        if (m > 64'd32768)
            m = 64'd32768;
        if (neg)
            return PIX_W'(-m);
        if (m > 64'd32767)
            return 16'h7FFF;
        return PIX_W'(m);
    endfunction

    function automatic frame_out_t predict_pixel(input pixel_t lanes);
        frame_out_t  o;
        logic [31:0] next;
        for (int k = 0; k < LANES; k++)
            o.res[k] = cfg_enable ? mish_code(lanes[k]) : lanes[k];
        next      = 32'(frame_pos) + 32'd1;
        o.last    = (next >= 32'(cfg_count));
        frame_pos = o.last ? '0 : next[IDX_W-1:0];
        return o;
    endfunction

    function automatic void log_pixel(input pixel_t lanes, input logic typed,
                                      input pixel_t want_res, input logic want_last);
        frame_out_t o;
        o = predict_pixel(lanes);
        if (typed)
        begin
            o.res  = want_res;
            o.last = want_last;
        end
        pending_results.push_back(o);
        pixels_sent++;
        if (cfg_enable)
            mish_pixels++;
    endfunction

    function automatic logic [PIX_W-1:0] rand_lane();
        logic [PIX_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = PIX_W'($urandom);
            4, 5, 6, 7: v = PIX_W'(int'($urandom_range(0, 3072)) - 1536);
            8:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default:
            begin
                v = PIX_W'($urandom_range(2560, 8192));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        for (int k = 0; k < LANES; k++)
            p[k] = rand_lane();
        return p;
    endfunction

    function automatic void check_result(input pixel_t got_res, input logic got_last);
        frame_out_t want;
        results_seen++;
        if (got_last)
            last_marks++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Result item with nothing pending: res %h last %b", got_res, got_last);
            return;
        end
        want = pending_results.pop_front();
        for (int k = 0; k < LANES; k++)
        begin
            if (got_res[k] !== want.res[k])
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result %0d lane %0d: expected %0d, got %0d", results_seen, k,
                             $signed(want.res[k]), $signed(got_res[k]));
            end
        end
        if (got_last !== want.last)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Result %0d frame_last: expected %b, got %b", results_seen,
                         want.last, got_last);
        end
    endfunction

    // Offer one pixel item and return at the edge where it is taken.
    task automatic offer_pixel(input pixel_t lanes);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.lane  <= lanes;
        do
            @(posedge clk);
        while (!pix.ready);
    endtask

    task automatic write_reg(input mla_reg_t addr, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Registers change only once the pipeline has drained.
    task automatic apply_settings(input logic en, input logic [CFG_W-1:0] cnt);
        pix.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        if (en != cfg_enable)
        begin
            write_reg(REG_ENABLE, CFG_W'(en));
            cfg_enable = en;
        end
        if (cnt != cfg_count)
        begin
            write_reg(REG_PIXEL_COUNT, cnt);
            cfg_count = cnt;
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        phase_t    ph;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_addr   <= REG_ENABLE;
        cfg_wdata  <= '0;
        pix.valid  <= 1'b0;
        pix.lane   <= '0;
        cfg_enable = 1'b0;
        cfg_count  = CFG_W'(1);
        frame_pos  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 19; i++)
        begin
            row = directed_rows[i];
            if (row.en != cfg_enable || row.cnt != cfg_count)
                apply_settings(row.en, row.cnt);
            offer_pixel(row.lanes);
            log_pixel(row.lanes, row.typed, row.want_res, row.want_last);
        end

        random_phases[4].cnt = CFG_W'($urandom_range(2, 40));
        for (int i = 0; i < 9; i++)
        begin
            ph = random_phases[i];
            apply_settings(ph.en, ph.cnt);
            gaps_on = ph.gaps;
            if (ph.hold)
                stall_requests++;
            for (int n = 0; n < int'(ph.items); n++)
            begin
                row.lanes = random_pixel();
                offer_pixel(row.lanes);
                log_pixel(row.lanes, 1'b0, '0, 1'b0);
            end
        end

        // Widest count: the position only climbs, so no pixel here closes a frame.
        apply_settings(1'b0, {CFG_W{1'b1}});
        for (int n = 0; n < WIDE_PASS; n++)
        begin
            row.lanes = {$urandom, $urandom};
            offer_pixel(row.lanes);
            log_pixel(row.lanes, 1'b0, '0, 1'b0);
        end
        pix.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d result items for %0d pixels, %0d through Mish, %0d frame ends.",
                 results_seen, pixels_sent, mish_pixels, last_marks);
        $display("Covered %0d settings, lane extremes, frame counts 0 to max, %0d-cycle stall.",
                 settings_used, LONG_HOLD);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_side
        int   hold_left;
        int   burst_left;
        logic rdy;
        hold_left  = 0;
        burst_left = 0;
        rdy        = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && rdy)
                check_result(res_ch.res, res_ch.frame_last);
            if (stall_requests != stall_served)
            begin
                stall_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                rdy = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 6) - 1;
                rdy        = 1'b0;
            end
            else
                rdy = 1'b1;
            res_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d result items pending", cycle_count,
                 pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
